// ----- src/q24a_pkg.sv -----
// Shared types, opcodes and saturation helpers for the Q24.8 fixed-point ALU.
// Used by q24a_front, q24a_div and q24_8_fixed_point_alu; depends on nothing.
`default_nettype none

package q24a_pkg;

   localparam int WORD_W = 32;

   localparam logic [WORD_W-1:0] MAX_VAL = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] MIN_VAL = {1'b1, {(WORD_W-1){1'b0}}};

   // Operation codes.
   typedef enum logic [3:0] {
      CMD_ADD       = 4'd0,
      CMD_SUB       = 4'd1,
      CMD_MUL       = 4'd2,
      CMD_DIV       = 4'd3,
      CMD_MIN       = 4'd4,
      CMD_MAX       = 4'd5,
      CMD_CMP       = 4'd6,
      CMD_INC       = 4'd7,
      CMD_DEC       = 4'd8,
      CMD_TOINT     = 4'd9,
      CMD_FROMINT   = 4'd10,
      CMD_FROMFLOAT = 4'd11
   } cmd_type;

   // Control and partial result that travel down the pipeline.
   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] result;
      logic              lt;
      logic              eq;
      logic              gt;
      logic              ovf;
      logic              dbz;
      logic              is_div;
      logic              neg;
   } ctl_type;

   // Saturates a 33-bit signed sum to the word range; bit 32 of the return is overflow.
   function automatic logic [WORD_W:0] sat33(input logic [WORD_W:0] s);
      logic [WORD_W:0] r;
      if (s[WORD_W] != s[WORD_W-1]) begin
         r = {1'b1, (s[WORD_W] ? MIN_VAL : MAX_VAL)};
      end else begin
         r = {1'b0, s[WORD_W-1:0]};
      end
      return r;
   endfunction

   // Applies a sign to a magnitude and saturates; bit 32 of the return is overflow.
   function automatic logic [WORD_W:0] sat_mag64(input logic neg, input logic [63:0] mag);
      logic [WORD_W:0] r;
      if (!neg) begin
         if (mag > 64'(MAX_VAL)) r = {1'b1, MAX_VAL};
         else r = {1'b0, mag[WORD_W-1:0]};
      end else if (mag > 64'(MIN_VAL)) begin
         r = {1'b1, MIN_VAL};
      end else begin
         r = {1'b0, (~mag[WORD_W-1:0]) + 32'd1};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- src/q24a_front.sv -----
// Front end of the ALU: three register stages that decode the transaction, finish
// every operation except divide, and prepare divider operands. Depends on q24a_pkg.
`default_nettype none

module q24a_front #(
   parameter int FRAC_BITS = 8
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   input  wire  [3:0]             cmd,
   input  wire  signed [31:0]     operand_a,
   input  wire  signed [31:0]     operand_b,
   output q24a_pkg::ctl_type      out_ctl,
   output logic [32+FRAC_BITS-1:0] out_num,
   output logic [31:0]            out_den
);

   localparam int NUM_W = 32 + FRAC_BITS;
   localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;
   localparam logic [32:0] LOW_MASK = (33'd1 << FRAC_BITS) - 33'd1;

   // Stage 1 combinational decode.
   q24a_pkg::ctl_type s1_in;
   logic              is_mul_in;
   logic [NUM_W-1:0]  num_in;
   logic [31:0]       den_in;
   logic [31:0]       mag_a;
   logic [32:0]       add_s, sub_s, inc_s, dec_s, toint_s, sat_r;
   logic signed [31:0] fi_top;
   logic              f_neg;
   logic [7:0]        f_ex;
   logic [23:0]       f_m;
   logic signed [9:0] f_s;
   logic [9:0]        f_sh;
   logic [63:0]       f_mag;
   logic [25:0]       f_rnd;
   logic [32:0]       f_r;

   always_comb begin
      s1_in        = '0;
      s1_in.valid  = in_valid;
      is_mul_in    = 1'b0;
      mag_a        = operand_a[31] ? (~operand_a) + 32'd1 : operand_a;
      den_in       = operand_b[31] ? (~operand_b) + 32'd1 : operand_b;
      num_in       = NUM_W'(mag_a) << FRAC_BITS;
      add_s        = {operand_a[31], operand_a} + {operand_b[31], operand_b};
      sub_s        = {operand_a[31], operand_a} - {operand_b[31], operand_b};
      inc_s        = {operand_a[31], operand_a} + 33'd1;
      dec_s        = {operand_a[31], operand_a} - 33'd1;
      toint_s      = {operand_a[31], operand_a} + (operand_a[31] ? LOW_MASK : 33'd0);
      fi_top       = operand_a >>> (31 - FRAC_BITS);
      sat_r        = '0;

      // Conversion from IEEE single.
      f_neg = operand_a[31];
      f_ex  = operand_a[30:23];
      f_m   = (f_ex != 8'd0) ? {1'b1, operand_a[22:0]} : {1'b0, operand_a[22:0]};
      f_s   = (f_ex != 8'd0) ? ($signed({2'b00, f_ex}) - 10'sd150 + 10'(FRAC_BITS))
                             : (-10'sd149 + 10'(FRAC_BITS));
      f_sh  = -f_s;
      f_mag = '0;
      f_rnd = (26'(f_m) + ((26'd1 << f_sh[4:0]) >> 1)) >> f_sh[4:0];
      if (f_ex == 8'hFF) begin
         f_r = (operand_a[22:0] != 23'd0) ? {1'b1, 32'd0}
                                          : {1'b1, (f_neg ? q24a_pkg::MIN_VAL
                                                          : q24a_pkg::MAX_VAL)};
      end else if (f_m == 24'd0) begin
         f_r = '0;
      end else if (f_s >= 10'sd0) begin
         if (f_s > 10'sd31) begin
            f_r = {1'b1, (f_neg ? q24a_pkg::MIN_VAL : q24a_pkg::MAX_VAL)};
         end else begin
            f_mag = 64'(f_m) << f_s[4:0];
            f_r   = q24a_pkg::sat_mag64(f_neg, f_mag);
         end
      end else if (f_sh >= 10'd25) begin
         f_r = '0;
      end else begin
         f_mag = 64'(f_rnd);
         f_r   = q24a_pkg::sat_mag64(f_neg, f_mag);
      end

      case (q24a_pkg::cmd_type'(cmd))
         q24a_pkg::CMD_ADD: begin
            sat_r = q24a_pkg::sat33(add_s);
            s1_in.result = sat_r[31:0];
            s1_in.ovf    = sat_r[32];
         end
         q24a_pkg::CMD_SUB: begin
            sat_r = q24a_pkg::sat33(sub_s);
            s1_in.result = sat_r[31:0];
            s1_in.ovf    = sat_r[32];
         end
         q24a_pkg::CMD_MUL: begin
            is_mul_in = 1'b1;
         end
         q24a_pkg::CMD_DIV: begin
            if (operand_b == 32'sd0) begin
               s1_in.dbz    = 1'b1;
               s1_in.result = operand_a[31] ? q24a_pkg::MIN_VAL : q24a_pkg::MAX_VAL;
            end else begin
               s1_in.is_div = 1'b1;
               s1_in.neg    = operand_a[31] ^ operand_b[31];
            end
         end
         q24a_pkg::CMD_MIN: begin
            s1_in.result = (operand_a < operand_b) ? operand_a : operand_b;
         end
         q24a_pkg::CMD_MAX: begin
            s1_in.result = (operand_a >= operand_b) ? operand_a : operand_b;
         end
         q24a_pkg::CMD_CMP: begin
            s1_in.lt = operand_a < operand_b;
            s1_in.eq = operand_a == operand_b;
            s1_in.gt = operand_a > operand_b;
         end
         q24a_pkg::CMD_INC: begin
            sat_r = q24a_pkg::sat33(inc_s);
            s1_in.result = sat_r[31:0];
            s1_in.ovf    = sat_r[32];
         end
         q24a_pkg::CMD_DEC: begin
            sat_r = q24a_pkg::sat33(dec_s);
            s1_in.result = sat_r[31:0];
            s1_in.ovf    = sat_r[32];
         end
         q24a_pkg::CMD_TOINT: begin
            s1_in.result = 32'($signed(toint_s) >>> FRAC_BITS);
         end
         q24a_pkg::CMD_FROMINT: begin
            if (fi_top == 32'sd0 || fi_top == -32'sd1) begin
               s1_in.result = operand_a << FRAC_BITS;
            end else begin
               s1_in.ovf    = 1'b1;
               s1_in.result = operand_a[31] ? q24a_pkg::MIN_VAL : q24a_pkg::MAX_VAL;
            end
         end
         q24a_pkg::CMD_FROMFLOAT: begin
            s1_in.result = f_r[31:0];
            s1_in.ovf    = f_r[32];
         end
         default: begin
            s1_in.result = '0;
         end
      endcase
   end

   // Stage 1 registers; the multiplier output is registered here.
   q24a_pkg::ctl_type  s1_ctl_ff;
   logic               s1_mul_ff;
   logic signed [63:0] s1_prod_ff;
   logic [NUM_W-1:0]   s1_num_ff;
   logic [31:0]        s1_den_ff;

   always_ff @(posedge clock) begin
      s1_mul_ff  <= is_mul_in;
      s1_prod_ff <= operand_a * operand_b;
      s1_num_ff  <= num_in;
      s1_den_ff  <= den_in;
      if (reset) begin
         s1_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= s1_in;
      end
   end

   // Stage 2: magnitude of the product plus the rounding half in one adder.
   logic [63:0] s2_sum_in;
   assign s2_sum_in = s1_prod_ff[63] ? ((~s1_prod_ff) + (HALF + 64'd1))
                                     : (s1_prod_ff + HALF);

   q24a_pkg::ctl_type s2_ctl_ff;
   logic              s2_mul_ff;
   logic              s2_neg_ff;
   logic [63:0]       s2_sum_ff;
   logic [NUM_W-1:0]  s2_num_ff;
   logic [31:0]       s2_den_ff;

   always_ff @(posedge clock) begin
      s2_mul_ff <= s1_mul_ff;
      s2_neg_ff <= s1_prod_ff[63];
      s2_sum_ff <= s2_sum_in;
      s2_num_ff <= s1_num_ff;
      s2_den_ff <= s1_den_ff;
      if (reset) begin
         s2_ctl_ff <= '0;
      end else begin
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   // Stage 3: scale down the product and saturate.
   logic [32:0]       mul_r;
   q24a_pkg::ctl_type s3_in;

   always_comb begin
      mul_r = q24a_pkg::sat_mag64(s2_neg_ff, s2_sum_ff >> FRAC_BITS);
      s3_in = s2_ctl_ff;
      if (s2_mul_ff) begin
         s3_in.result = mul_r[31:0];
         s3_in.ovf    = mul_r[32];
      end
   end

   q24a_pkg::ctl_type s3_ctl_ff;
   logic [NUM_W-1:0]  s3_num_ff;
   logic [31:0]       s3_den_ff;

   always_ff @(posedge clock) begin
      s3_num_ff <= s2_num_ff;
      s3_den_ff <= s2_den_ff;
      if (reset) begin
         s3_ctl_ff <= '0;
      end else begin
         s3_ctl_ff <= s3_in;
      end
   end

   assign out_ctl = s3_ctl_ff;
   assign out_num = s3_num_ff;
   assign out_den = s3_den_ff;

endmodule

`default_nettype wire

// ----- src/q24a_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, followed by a rounding
// stage and a saturation stage that also act as the output register. Depends on q24a_pkg.
`default_nettype none

module q24a_div #(
   parameter int FRAC_BITS = 8
) (
   input  wire                     clock,
   input  wire                     reset,
   input  q24a_pkg::ctl_type       in_ctl,
   input  wire  [32+FRAC_BITS-1:0] in_num,
   input  wire  [31:0]             in_den,
   output q24a_pkg::ctl_type       out_ctl
);

   localparam int NUM_W = 32 + FRAC_BITS;

   // Per-stage state: partial remainder, shared dividend/quotient shift word.
   q24a_pkg::ctl_type ctl_ff [NUM_W];
   logic [31:0]       rem_ff [NUM_W];
   logic [NUM_W-1:0]  nq_ff  [NUM_W];
   logic [31:0]       den_ff [NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      q24a_pkg::ctl_type c_prev;
      logic [31:0]       r_prev;
      logic [NUM_W-1:0]  nq_prev;
      logic [31:0]       d_prev;
      logic [32:0]       trial;
      logic [32:0]       diff;

      if (i == 0) begin : g_first
         assign c_prev  = in_ctl;
         assign r_prev  = 32'd0;
         assign nq_prev = in_num;
         assign d_prev  = in_den;
      end else begin : g_next
         assign c_prev  = ctl_ff[i-1];
         assign r_prev  = rem_ff[i-1];
         assign nq_prev = nq_ff[i-1];
         assign d_prev  = den_ff[i-1];
      end

      // Shift in the next dividend bit and try subtracting the divisor.
      assign trial = {r_prev, nq_prev[NUM_W-1]};
      assign diff  = trial - {1'b0, d_prev};

      always_ff @(posedge clock) begin
         den_ff[i] <= d_prev;
         if (!diff[32]) begin
            rem_ff[i] <= diff[31:0];
            nq_ff[i]  <= {nq_prev[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff[i] <= trial[31:0];
            nq_ff[i]  <= {nq_prev[NUM_W-2:0], 1'b0};
         end
         if (reset) begin
            ctl_ff[i] <= '0;
         end else begin
            ctl_ff[i] <= c_prev;
         end
      end
   end

   // Rounding: bump the quotient when twice the remainder reaches the divisor.
   logic              round_up;
   q24a_pkg::ctl_type rnd_ctl_ff;
   logic [NUM_W:0]    rnd_q_ff;

   assign round_up = {rem_ff[NUM_W-1], 1'b0} >= {1'b0, den_ff[NUM_W-1]};

   always_ff @(posedge clock) begin
      rnd_q_ff <= (NUM_W+1)'(nq_ff[NUM_W-1]) + (NUM_W+1)'(round_up);
      if (reset) begin
         rnd_ctl_ff <= '0;
      end else begin
         rnd_ctl_ff <= ctl_ff[NUM_W-1];
      end
   end

   // Sign and saturation of the quotient; other operations pass through.
   logic [32:0]       quo_r;
   q24a_pkg::ctl_type fin_in;
   q24a_pkg::ctl_type fin_ff;

   always_comb begin
      quo_r  = q24a_pkg::sat_mag64(rnd_ctl_ff.neg, 64'(rnd_q_ff));
      fin_in = rnd_ctl_ff;
      if (rnd_ctl_ff.is_div) begin
         fin_in.result = quo_r[31:0];
         fin_in.ovf    = quo_r[32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff <= '0;
      end else begin
         fin_ff <= fin_in;
      end
   end

   assign out_ctl = fin_ff;

endmodule

`default_nettype wire

// ----- src/q24_8_fixed_point_alu.sv -----
// Top level of the signed Q24.8 fixed-point ALU: front end and divider pipeline.
// Depends on q24a_pkg, q24a_front and q24a_div.
`default_nettype none

// Fully pipelined ALU. A transaction is taken on every cycle that start is high;
// busy is always low. Every operation has the same latency and passes through
// three front-end stages (decode and multiply, rounding, scale and saturate),
// the restoring divider, which resolves one quotient bit per stage over
// 32 + FRAC_BITS stages, and two back-end stages (round and saturate).
// Results leave in transaction order with rsp_valid high for exactly one cycle;
// there is no back-pressure, so the receiver must take each result as it appears.
module q24_8_fixed_point_alu #(
   parameter int FRAC_BITS = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  wire  [3:0]        req_cmd,
   input  wire  signed [31:0] req_operand_a,
   input  wire  signed [31:0] req_operand_b,
   output logic              rsp_valid,
   output logic signed [31:0] rsp_result_value,
   output logic              rsp_is_less,
   output logic              rsp_is_equal,
   output logic              rsp_is_greater,
   output logic              rsp_overflowed,
   output logic              rsp_divided_by_zero
);

   localparam int NUM_W   = 32 + FRAC_BITS;
   localparam int LATENCY = NUM_W + 5;

   q24a_pkg::ctl_type front_ctl;
   q24a_pkg::ctl_type back_ctl;
   logic [NUM_W-1:0]  front_num;
   logic [31:0]       front_den;

   // The pipeline never stalls.
   assign busy = 1'b0;

   q24a_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .cmd       (req_cmd),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .out_ctl   (front_ctl),
      .out_num   (front_num),
      .out_den   (front_den)
   );

   q24a_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (front_ctl),
      .in_num  (front_num),
      .in_den  (front_den),
      .out_ctl (back_ctl)
   );

   // Drive the result ports from the final stage.
   assign rsp_valid           = back_ctl.valid;
   assign rsp_result_value    = back_ctl.result;
   assign rsp_is_less         = back_ctl.lt;
   assign rsp_is_equal        = back_ctl.eq;
   assign rsp_is_greater      = back_ctl.gt;
   assign rsp_overflowed      = back_ctl.ovf;
   assign rsp_divided_by_zero = back_ctl.dbz;

`ifndef SYNTHESIS
   // Every result comes from a transaction taken exactly one latency earlier.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a matching transaction");

   // At most one compare flag is set.
   a_cmp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_is_less, rsp_is_equal, rsp_is_greater}))
      else $error("more than one compare flag set");

   // Division by zero never reports overflow as well.
   a_dbz_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_divided_by_zero |-> !rsp_overflowed)
      else $error("divide by zero also flagged overflow");

   // Compare results carry a zero value.
   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_is_less || rsp_is_equal || rsp_is_greater) |-> (rsp_result_value == 32'sd0))
      else $error("compare result has nonzero value");
`endif

endmodule

`default_nettype wire
